// ===== src/luma_sobel_edge_magnitude_macros.svh =====
// Assertion macros for the luma Sobel edge magnitude block.
`ifndef LUMA_SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define LUMA_SOBEL_EDGE_MAGNITUDE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication: pre |-> post
`define LSEM_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lsem assertion failed");

// Next-cycle implication: pre |=> post
`define LSEM_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lsem assertion failed");

`else

`define LSEM_ASSERT_NOW(name, clk, rst_n, pre, post)

`define LSEM_ASSERT_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

// ===== src/lsem_pkg.sv =====
// Shared constants and controller/datapath interface types.
`timescale 1ns / 1ps

package lsem_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int MIN_DIM        = 3;

    localparam int FRAME_WIDTH_BITS  = 12;
    localparam int FRAME_HEIGHT_BITS = 13;
    localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    localparam int PIX_BITS      = 8;
    localparam int LUMA_SUM_BITS = 24;
    localparam logic [15:0] LUMA_W_RED   = 16'd13933;
    localparam logic [15:0] LUMA_W_GREEN = 16'd46871;
    localparam logic [15:0] LUMA_W_BLUE  = 16'd4732;
    localparam logic [LUMA_SUM_BITS-1:0] LUMA_ROUND = 24'd32768;

    localparam int GRAD_BITS = 12;   // signed, |g| <= 1020
    localparam int ABS_BITS  = 10;
    localparam int SQ_BITS   = 2 * ABS_BITS;
    localparam int NORM_BITS = SQ_BITS + 1;
    localparam int ROOT_BITS = 11;   // root of a 21-bit value
    localparam int ROOT_SQ_BITS = 2 * ROOT_BITS;
    localparam logic [ROOT_BITS-1:0] ROOT_FIRST_BIT = {1'b1, {(ROOT_BITS-1){1'b0}}};
    localparam logic [PIX_BITS-1:0]  PIX_MAX = {PIX_BITS{1'b1}};

    typedef struct packed {
        logic restart;
        logic load;
        logic fetch;
        logic luma;
        logic grad;
        logic square;
        logic root_step;
        logic round;
        logic emit;
    } lsem_cmd_t;

    typedef struct packed {
        logic interior;
        logic root_last;
        logic out_busy;
    } lsem_status_t;

endpackage

// ===== src/lsem_ctrl.sv =====
// Sequencer that walks one pixel item at a time through the datapath.
`timescale 1ns / 1ps
`include "luma_sobel_edge_magnitude_macros.svh"

module lsem_ctrl
    import lsem_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         cfg_restart,
    input  lsem_status_t status,
    output lsem_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LUMA,
        S_GRAD,
        S_SQUARE,
        S_ROOT,
        S_ROUND,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;

    assign in_stall = in_stall_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.restart = cfg_restart;
        unique case (state_reg)
            S_IDLE:   cmd.load      = in_valid && !in_stall_reg;
            S_FETCH:  cmd.fetch     = 1'b1;
            S_LUMA:   cmd.luma      = 1'b1;
            S_GRAD:   cmd.grad      = 1'b1;
            S_SQUARE: cmd.square    = 1'b1;
            S_ROOT:   cmd.root_step = 1'b1;
            S_ROUND:  cmd.round     = 1'b1;
            S_EMIT:   cmd.emit      = !status.out_busy;
            default:  cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall_reg)
                    begin
                        state_reg    <= S_FETCH;
                        in_stall_reg <= 1'b1;
                    end
                end
                S_FETCH:  state_reg <= S_LUMA;
                S_LUMA:   state_reg <= S_GRAD;
                S_GRAD:
                begin
                    // border pixels end here with no result
                    if (status.interior)
                    begin
                        state_reg <= S_SQUARE;
                    end
                    else
                    begin
                        state_reg    <= S_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                S_SQUARE: state_reg <= S_ROOT;
                S_ROOT:
                begin
                    if (status.root_last)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:  state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (!status.out_busy)
                    begin
                        state_reg    <= S_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_stall_reg <= 1'b0;
                end
            endcase
        end
    end

    `LSEM_ASSERT_NEXT(a_accept_stalls, clk, rst_n, in_valid && !in_stall, in_stall)
    `LSEM_ASSERT_NEXT(a_emit_frees_input, clk, rst_n, cmd.emit, !in_stall)
    `LSEM_ASSERT_NOW(a_one_step_at_a_time, clk, rst_n, in_stall, !cmd.load)

endmodule

// ===== src/lsem_datapath.sv =====
// Luma, line stores, 3x3 window, Sobel, iterative root and output register.
`timescale 1ns / 1ps
`include "luma_sobel_edge_magnitude_macros.svh"

module lsem_datapath
    import lsem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lsem_cmd_t           cmd,
    output lsem_status_t        status,
    input  logic [PIX_BITS-1:0] blue,
    input  logic [PIX_BITS-1:0] green,
    input  logic [PIX_BITS-1:0] red,
    input  logic [WW-1:0]       width_eff,
    input  logic [HW-1:0]       height_eff,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PIX_BITS-1:0] edge_magnitude,
    output logic                frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [PIX_BITS-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_BITS-1:0] middle_mem [MAX_WIDTH];

    logic [PIX_BITS-1:0]      blue_reg, green_reg, red_reg;
    logic [LUMA_SUM_BITS-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [PIX_BITS-1:0]      top_rd_reg, mid_rd_reg, luma_reg;
    // window: 0..2 column c-2 (top, mid, bottom), 3..5 column c-1
    logic [PIX_BITS-1:0]      win_reg [6];
    logic [CW-1:0]            col_reg;
    logic [RW-1:0]            row_reg;
    logic [ABS_BITS-1:0]      gx_abs_reg, gy_abs_reg;
    logic                     last_pend_reg;
    logic [NORM_BITS-1:0]     norm_reg;
    logic [ROOT_BITS-1:0]     root_reg, bit_reg;
    logic [PIX_BITS-1:0]      res_reg;
    logic                     out_valid_reg;
    logic [PIX_BITS-1:0]      out_mag_reg;
    logic                     out_last_reg;

    logic                     col_last, row_last, interior;
    logic [LUMA_SUM_BITS-1:0] luma_sum;
    logic signed [GRAD_BITS-1:0] tl, ml, bl, tc, bc, tr, mr, br, gx, gy;
    logic [GRAD_BITS-1:0]     gx_mag, gy_mag;
    logic [SQ_BITS-1:0]       sq_x, sq_y;
    logic [ROOT_BITS-1:0]     trial;
    logic [ROOT_SQ_BITS-1:0]  trial_sq, root_sq, rem_wide;
    logic [ROOT_BITS:0]       rounded;
    logic [PIX_BITS-1:0]      rounded_sat;

    function automatic logic signed [GRAD_BITS-1:0] to_s(input logic [PIX_BITS-1:0] v);
        return $signed({{(GRAD_BITS-PIX_BITS){1'b0}}, v});
    endfunction

    assign col_last = (WW'(col_reg) == width_eff - WW'(1));
    assign row_last = (HW'(row_reg) == height_eff - HW'(1));
    assign interior = (col_reg >= CW'(2)) && (row_reg >= RW'(2));

    assign luma_sum = prod_r_reg + prod_g_reg + prod_b_reg + LUMA_ROUND;

    always_comb
    begin
        tl = to_s(win_reg[0]);
        ml = to_s(win_reg[1]);
        bl = to_s(win_reg[2]);
        tc = to_s(win_reg[3]);
        bc = to_s(win_reg[5]);
        tr = to_s(top_rd_reg);
        mr = to_s(mid_rd_reg);
        br = to_s(luma_reg);
        gx = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
        gy = (bl - tl) + ((bc - tc) <<< 1) + (br - tr);
        gx_mag = gx[GRAD_BITS-1] ? $unsigned(-gx) : $unsigned(gx);
        gy_mag = gy[GRAD_BITS-1] ? $unsigned(-gy) : $unsigned(gy);
    end

    assign sq_x = gx_abs_reg * gx_abs_reg;
    assign sq_y = gy_abs_reg * gy_abs_reg;

    assign trial    = root_reg | bit_reg;
    assign trial_sq = trial * trial;
    assign root_sq  = root_reg * root_reg;
    assign rem_wide = ROOT_SQ_BITS'(norm_reg) - root_sq;

    always_comb
    begin
        // round to nearest: bump when the remainder exceeds the floor root
        if (rem_wide > ROOT_SQ_BITS'(root_reg))
        begin
            rounded = {1'b0, root_reg} + (ROOT_BITS+1)'(1);
        end
        else
        begin
            rounded = {1'b0, root_reg};
        end
        if (rounded > (ROOT_BITS+1)'(PIX_MAX))
        begin
            rounded_sat = PIX_MAX;
        end
        else
        begin
            rounded_sat = rounded[PIX_BITS-1:0];
        end
    end

    assign status.interior  = interior;
    assign status.root_last = bit_reg[0];
    assign status.out_busy  = out_valid_reg && out_stall;

    assign out_valid      = out_valid_reg;
    assign edge_magnitude = out_mag_reg;
    assign frame_last     = out_last_reg;

    // line stores
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            top_rd_reg <= upper_mem[col_reg];
            mid_rd_reg <= middle_mem[col_reg];
        end
        if (cmd.grad)
        begin
            upper_mem[col_reg]  <= mid_rd_reg;
            middle_mem[col_reg] <= luma_reg;
        end
    end

    // control state: position in frame, window, root bit, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
                for (int i = 0; i < 6; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else if (cmd.grad)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_rd_reg;
                win_reg[4] <= mid_rd_reg;
                win_reg[5] <= luma_reg;
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_last ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end

            if (cmd.square)
            begin
                bit_reg <= ROOT_FIRST_BIT;
            end
            else if (cmd.root_step)
            begin
                bit_reg <= bit_reg >> 1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            blue_reg  <= blue;
            green_reg <= green;
            red_reg   <= red;
        end
        if (cmd.fetch)
        begin
            prod_r_reg <= LUMA_SUM_BITS'(LUMA_W_RED) * LUMA_SUM_BITS'(red_reg);
            prod_g_reg <= LUMA_SUM_BITS'(LUMA_W_GREEN) * LUMA_SUM_BITS'(green_reg);
            prod_b_reg <= LUMA_SUM_BITS'(LUMA_W_BLUE) * LUMA_SUM_BITS'(blue_reg);
        end
        if (cmd.luma)
        begin
            // weights sum to one, so the top byte never overflows
            luma_reg <= luma_sum[LUMA_SUM_BITS-1 -: PIX_BITS];
        end
        if (cmd.grad)
        begin
            gx_abs_reg    <= gx_mag[ABS_BITS-1:0];
            gy_abs_reg    <= gy_mag[ABS_BITS-1:0];
            last_pend_reg <= col_last && row_last;
        end
        if (cmd.square)
        begin
            norm_reg <= NORM_BITS'(sq_x) + NORM_BITS'(sq_y);
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            if (trial_sq <= ROOT_SQ_BITS'(norm_reg))
            begin
                root_reg <= trial;
            end
        end
        if (cmd.round)
        begin
            res_reg <= rounded_sat;
        end
        if (cmd.emit)
        begin
            out_mag_reg  <= res_reg;
            out_last_reg <= last_pend_reg;
        end
    end

    `LSEM_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.emit, !status.out_busy)
    `LSEM_ASSERT_NOW(a_root_bit_live, clk, rst_n, cmd.root_step, bit_reg != '0)
    `LSEM_ASSERT_NEXT(a_restart_clears, clk, rst_n, cmd.restart, col_reg == '0 && row_reg == '0)

endmodule

// ===== src/luma_sobel_edge_magnitude.sv =====
// Top level: register port, dimension clamp, controller and datapath.
`timescale 1ns / 1ps
//
// Sobel edge magnitude over BT.709 luma of a raster-order BGR pixel stream.
// Input channel: in_valid / in_stall with blue, green, red; an item moves
// on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with edge_magnitude and frame_last;
// one result per interior pixel, frame_last marks the last of the frame.
// Pixels in the first two rows or columns give no result.
// Pixels are handled one at a time by a sequencer. A border pixel passes
// through fetch, luma and gradient and then frees the input. An interior
// pixel goes on to the squares, the 11-bit bit-by-bit square root (one
// trial square per cycle), rounding and hand-off to out_valid.
// The result sits in an output register, so a stalled receiver holds
// the sequencer only once the following interior pixel is ready to emit;
// border pixels before it keep flowing.
// Reset: frame 640 x 480, counters and window cleared, output empty; the
// line stores are not cleared and are always rewritten before use.
// Any write of frame_width (addr 0) or frame_height (addr 4) restarts the
// frame; write only while the block is idle.
//
module luma_sobel_edge_magnitude
    import lsem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [PIX_BITS-1:0]      blue,
    input  logic [PIX_BITS-1:0]      green,
    input  logic [PIX_BITS-1:0]      red,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [PIX_BITS-1:0]      edge_magnitude,
    output logic                     frame_last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [FRAME_WIDTH_BITS-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_BITS-1:0] frame_height_reg;
    logic                         cfg_write;
    reg_index_t                   cfg_index;
    logic [WW-1:0]                width_eff;
    logic [HW-1:0]                height_eff;
    lsem_cmd_t                    cmd;
    lsem_status_t                 status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    // word addressed; low byte-lane bits are ignored
    assign cfg_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FRAME_WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FRAME_HEIGHT_BITS-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // clamp dimensions to MIN_DIM..MAX
    always_comb
    begin
        if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else if (frame_width_reg < FRAME_WIDTH_BITS'(MIN_DIM))
        begin
            width_eff = WW'(MIN_DIM);
        end
        else
        begin
            width_eff = WW'(frame_width_reg);
        end

        if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            height_eff = HW'(MAX_HEIGHT);
        end
        else if (frame_height_reg < FRAME_HEIGHT_BITS'(MIN_DIM))
        begin
            height_eff = HW'(MIN_DIM);
        end
        else
        begin
            height_eff = HW'(frame_height_reg);
        end
    end

    lsem_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cfg_restart (cfg_write),
        .status      (status),
        .cmd         (cmd)
    );

    lsem_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .width_eff      (width_eff),
        .height_eff     (height_eff),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .edge_magnitude (edge_magnitude),
        .frame_last     (frame_last)
    );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the luma Sobel edge magnitude block.
`timescale 1ns / 1ps

module testbench;
    import lsem_pkg::*;

    localparam int SETTLE_CYCLES  = 40;    // longer than an interior pixel takes to pass through
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item, result or write
    localparam int SMALL_ITEMS    = 500;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } pixel_t;

    typedef struct packed {
        logic [7:0] mag;
        logic       last;
    } edge_result_t;

    typedef enum int {
        IMG_NOISE,
        IMG_SMOOTH,
        IMG_BINARY
    } image_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [PIX_BITS-1:0]      blue = '0;
    logic [PIX_BITS-1:0]      green = '0;
    logic [PIX_BITS-1:0]      red = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [PIX_BITS-1:0]      edge_magnitude;
    logic                     frame_last;

    // predictor state
    logic [7:0]                   luma_upper [DEF_MAX_WIDTH];
    logic [7:0]                   luma_middle [DEF_MAX_WIDTH];
    logic [7:0]                   win_luma [6];
    int                           col_pos;
    int                           row_pos;
    logic [FRAME_WIDTH_BITS-1:0]  cfg_width;
    logic [FRAME_HEIGHT_BITS-1:0] cfg_height;

    pixel_t       pixel_q[$];
    edge_result_t expected_edges[$];
    edge_result_t head_edge;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int idle_by_mode[4] = '{0, 68, 0, 17};
    int stall_by_mode[4] = '{0, 0, 68, 17};

    luma_sobel_edge_magnitude dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .blue(blue),
        .green(green),
        .red(red),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .edge_magnitude(edge_magnitude),
        .frame_last(frame_last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [7:0] bt709_luma(input logic [7:0] b, input logic [7:0] g,
                                              input logic [7:0] r);
        logic [31:0] acc;
        acc = 32'(LUMA_W_RED) * r + 32'(LUMA_W_GREEN) * g + 32'(LUMA_W_BLUE) * b
            + 32'(LUMA_ROUND);
        acc = acc >> 16;
        return (acc > 255) ? PIX_MAX : acc[7:0];
    endfunction

    // floor root by bit trials, then round to nearest and saturate
    function automatic logic [7:0] rounded_root(input int unsigned n);
        int unsigned s;
        int unsigned t;
        s = 0;
        for (int k = 11; k >= 0; k--)
        begin
            t = s | (32'd1 << k);
            if (t * t <= n)
                s = t;
        end
        if (n - s * s > s)
            s++;
        return (s > 255) ? PIX_MAX : s[7:0];
    endfunction

    function automatic void restart_frame();
        for (int i = 0; i < 6; i++)
            win_luma[i] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    task automatic predict_edge(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        int w, h, c, row;
        int y, top, mid, tl, ml, bl, tc, bc, gx, gy;
        int unsigned n;
        edge_result_t res;
        w = clamp_dim(int'(cfg_width), DEF_MAX_WIDTH);
        h = clamp_dim(int'(cfg_height), DEF_MAX_HEIGHT);
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        row = row_pos;
        y = int'(bt709_luma(b, g, r));
        top = int'(luma_upper[c]);
        mid = int'(luma_middle[c]);
        if (row >= 2 && c >= 2)
        begin
            tl = int'(win_luma[0]);
            ml = int'(win_luma[1]);
            bl = int'(win_luma[2]);
            tc = int'(win_luma[3]);
            bc = int'(win_luma[5]);
            gx = (top - tl) + 2 * (mid - ml) + (y - bl);
            gy = (bl - tl) + 2 * (bc - tc) + (y - top);
            n = unsigned'(gx * gx + gy * gy);
            res.mag = rounded_root(n);
            res.last = (row == h - 1 && c == w - 1);
            expected_edges.push_back(res);
        end
        luma_upper[c] = mid[7:0];
        luma_middle[c] = y[7:0];
        win_luma[0] = win_luma[3];
        win_luma[1] = win_luma[4];
        win_luma[2] = win_luma[5];
        win_luma[3] = top[7:0];
        win_luma[4] = mid[7:0];
        win_luma[5] = y[7:0];
        c++;
        if (c >= w)
        begin
            c = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        col_pos = c;
        row_pos = row;
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_edge(blue, green, red);
                pixel_q.delete(0);
            end
            if (!(in_valid && in_stall))
            begin
                if (pixel_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    blue <= pixel_q[0].b;
                    green <= pixel_q[0].g;
                    red <= pixel_q[0].r;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_edges.size() == 0)
                begin
                    $display("%0t: unexpected result edge_magnitude %0d frame_last %0d",
                             $time, edge_magnitude, frame_last);
                    mismatch_count++;
                end
                else
                begin
                    head_edge = expected_edges.pop_front();
                    if (edge_magnitude !== head_edge.mag)
                    begin
                        $display("%0t: edge_magnitude expected %0d actual %0d",
                                 $time, head_edge.mag, edge_magnitude);
                        mismatch_count++;
                    end
                    if (frame_last !== head_edge.last)
                    begin
                        $display("%0t: frame_last expected %0d actual %0d",
                                 $time, head_edge.last, frame_last);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cfg_width = value[FRAME_WIDTH_BITS-1:0];
            REG_FRAME_HEIGHT: cfg_height = value[FRAME_HEIGHT_BITS-1:0];
            default: ;
        endcase
        restart_frame();
    endtask

    task automatic drain_and_settle();
        while (pixel_q.size() != 0 || expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void push_pixel(input logic [7:0] b, input logic [7:0] g,
                                       input logic [7:0] r);
        pixel_t px;
        px.b = b;
        px.g = g;
        px.r = r;
        pixel_q.push_back(px);
    endfunction

    function automatic logic [7:0] near_level(input logic [7:0] base);
        int v;
        v = base + $urandom_range(0, 12);
        return (v > 255) ? PIX_MAX : v[7:0];
    endfunction

    task automatic run_phase(input logic [31:0] w_val, input logic [31:0] h_val,
                             input int n_pix, input int idle_mode, input image_mode_t img);
        logic [7:0] base_b, base_g, base_r, v;
        write_reg(REG_FRAME_WIDTH, w_val);
        write_reg(REG_FRAME_HEIGHT, h_val);
        sender_idle_pct = idle_by_mode[idle_mode];
        recv_stall_pct = stall_by_mode[idle_mode];
        base_b = 8'($urandom_range(0, 255));
        base_g = 8'($urandom_range(0, 255));
        base_r = 8'($urandom_range(0, 255));
        for (int i = 0; i < n_pix; i++)
        begin
            case (img)
                IMG_NOISE:
                    push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                IMG_SMOOTH:
                    push_pixel(near_level(base_b), near_level(base_g), near_level(base_r));
                default:
                begin
                    v = $urandom_range(0, 1) ? PIX_MAX : 8'd0;
                    push_pixel(v, v, v);
                end
            endcase
        end
        drain_and_settle();
    endtask

    initial
    begin
        int ramp[9];
        int small_items;
        int phase;
        int w, h, w_raw, h_raw, n, k;
        image_mode_t img;

        ramp = '{100, 100, 100, 100, 100, 101, 100, 101, 103};
        cfg_width = FRAME_WIDTH_RESET;
        cfg_height = FRAME_HEIGHT_RESET;
        for (int i = 0; i < DEF_MAX_WIDTH; i++)
        begin
            luma_upper[i] = '0;
            luma_middle[i] = '0;
        end
        restart_frame();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset dimensions: first row only, so nothing comes out
        for (int i = 0; i < 10; i++)
            push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        drain_and_settle();

        // 3x3 frames: full vertical edge, primary colors, shallow ramp
        write_reg(REG_FRAME_WIDTH, 32'd3);
        write_reg(REG_FRAME_HEIGHT, 32'd3);
        for (int i = 0; i < 3; i++)
        begin
            push_pixel(8'd0, 8'd0, 8'd0);
            push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
            push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
        end
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(PIX_MAX, 8'd0, 8'd0);
        push_pixel(8'd0, PIX_MAX, 8'd0);
        push_pixel(8'd0, 8'd0, PIX_MAX);
        push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
        push_pixel(8'd0, PIX_MAX, PIX_MAX);
        push_pixel(PIX_MAX, PIX_MAX, 8'd0);
        for (int i = 0; i < 9; i++)
            push_pixel(8'(ramp[i]), 8'(ramp[i]), 8'(ramp[i]));
        drain_and_settle();

        small_items = 0;
        phase = 0;
        while (small_items < SMALL_ITEMS)
        begin
            k = $urandom_range(0, 9);
            w_raw = (k == 0) ? $urandom_range(0, 2) :
                    (k == 1) ? $urandom_range(11, 24) : $urandom_range(3, 10);
            k = $urandom_range(0, 9);
            h_raw = (k == 0) ? $urandom_range(0, 2) :
                    (k == 1) ? 10 : $urandom_range(3, 6);
            w = clamp_dim(w_raw, DEF_MAX_WIDTH);
            h = clamp_dim(h_raw, DEF_MAX_HEIGHT);
            n = w * h * $urandom_range(1, 3);
            // a trailing partial frame gets cut off by the next write
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, w * h - 1);
            k = $urandom_range(0, 3);
            img = (k == 0) ? IMG_NOISE : (k == 3) ? IMG_BINARY : IMG_SMOOTH;
            // stray upper bits are dropped by the register width
            if ($urandom_range(0, 7) == 0)
                w_raw = w_raw | ($urandom() & 32'hFFFF_0000);
            run_phase(w_raw, h_raw, n, phase % 4, img);
            small_items += n;
            phase++;
        end

        // wide line and saturated dimensions
        run_phase(32'd64, 32'd3, 64 * 3 + 6, 0, IMG_SMOOTH);
        run_phase(32'd4095, 32'd1, 40, 3, IMG_NOISE);
        run_phase(32'd3, 32'd8191, 60, 1, IMG_SMOOTH);
        run_phase(32'd3, 32'd4096, 30, 2, IMG_NOISE);
        run_phase(32'd0, 32'd0, 9 * 4 + 2, 0, IMG_BINARY);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
